// ----- src/tia_pkg.sv -----
// Shared opcode constants and widths for the tagged integer ALU.
package tia_pkg;

    localparam int WORD_W    = 64;
    localparam int OP_W      = 5;
    localparam int DIV_STEPS = 63;

    localparam logic [OP_W-1:0] OP_ADD    = 5'd0;
    localparam logic [OP_W-1:0] OP_NEG    = 5'd1;
    localparam logic [OP_W-1:0] OP_SUB    = 5'd2;
    localparam logic [OP_W-1:0] OP_MUL    = 5'd3;
    localparam logic [OP_W-1:0] OP_DIV    = 5'd4;
    localparam logic [OP_W-1:0] OP_MOD    = 5'd5;
    localparam logic [OP_W-1:0] OP_OFFSET = 5'd6;
    localparam logic [OP_W-1:0] OP_AND    = 5'd7;
    localparam logic [OP_W-1:0] OP_OR     = 5'd8;
    localparam logic [OP_W-1:0] OP_XOR    = 5'd9;
    localparam logic [OP_W-1:0] OP_LSL    = 5'd10;
    localparam logic [OP_W-1:0] OP_LSR    = 5'd11;
    localparam logic [OP_W-1:0] OP_ASR    = 5'd12;
    localparam logic [OP_W-1:0] OP_ISINT  = 5'd13;
    localparam logic [OP_W-1:0] OP_NOT    = 5'd14;
    localparam logic [OP_W-1:0] OP_EQ     = 5'd15;
    localparam logic [OP_W-1:0] OP_NEQ    = 5'd16;
    localparam logic [OP_W-1:0] OP_LT     = 5'd17;
    localparam logic [OP_W-1:0] OP_LE     = 5'd18;
    localparam logic [OP_W-1:0] OP_GT     = 5'd19;
    localparam logic [OP_W-1:0] OP_GE     = 5'd20;
    localparam logic [OP_W-1:0] OP_ULT    = 5'd21;
    localparam logic [OP_W-1:0] OP_UGE    = 5'd22;

    localparam logic [WORD_W-1:0] TAG_FALSE = 64'd1;
    localparam logic [WORD_W-1:0] TAG_TRUE  = 64'd3;

    // Tagged boolean from a condition
    function automatic logic [WORD_W-1:0] tbool(input logic c);
        return c ? TAG_TRUE : TAG_FALSE;
    endfunction

endpackage

// ----- src/tagged_integer_alu.sv -----
// Top level: pipelined tagged integer ALU with a one-bit-per-stage divider.
//
// Use: present a request on in_valid with req_type, accu_value,
// stack_top_value and raw_offset; it is taken at a clock edge where
// in_valid is high and in_stall is low. The new accumulator word and the
// divide_by_zero flag come out on out_valid, held until out_stall is low.
// Every opcode takes the same path from the accepting edge to out_valid:
// an input register, an operand stage (simple results, three
// 32x32 partial products, divider magnitudes), a partial-product sum
// stage, 63 restoring divider stages (one quotient bit each) and the
// output register. One request is taken every cycle while not stalled.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
// Divide or modulo by zero (stack top word 0 or 1) gives 1 and raises divide_by_zero.
module tagged_integer_alu
    import tia_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          req_type,
    input  logic signed [WORD_W-1:0] accu_value,
    input  logic signed [WORD_W-1:0] stack_top_value,
    input  logic signed [WORD_W-1:0] raw_offset,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WORD_W-1:0] result_value,
    output logic                     divide_by_zero
);

    logic adv;

    // Pipeline moves unless a finished result is held
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // Input register
    logic              v0_reg;
    logic [OP_W-1:0]   op0_reg;
    logic [WORD_W-1:0] a0_reg, b0_reg, off0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op0_reg  <= req_type;
            a0_reg   <= accu_value;
            b0_reg   <= stack_top_value;
            off0_reg <= raw_offset;
        end
    end

    // Operand stage: simple results, partial products, divider magnitudes
    logic [WORD_W-1:0] ua, ub, am1, nabs, dabs, simple_next;
    logic [5:0]        sh;

    assign ua   = {a0_reg[WORD_W-1], a0_reg[WORD_W-1:1]};
    assign ub   = {b0_reg[WORD_W-1], b0_reg[WORD_W-1:1]};
    assign am1  = a0_reg - 64'd1;
    assign sh   = b0_reg[6:1];
    assign nabs = ua[WORD_W-1] ? (64'd0 - ua) : ua;
    assign dabs = ub[WORD_W-1] ? (64'd0 - ub) : ub;

    always_comb
    begin
        case (op0_reg)
            OP_ADD:    simple_next = a0_reg + b0_reg - 64'd1;
            OP_NEG:    simple_next = 64'd2 - a0_reg;
            OP_SUB:    simple_next = a0_reg - b0_reg + 64'd1;
            OP_OFFSET: simple_next = a0_reg + off0_reg;
            OP_AND:    simple_next = a0_reg & b0_reg;
            OP_OR:     simple_next = a0_reg | b0_reg;
            OP_XOR:    simple_next = (a0_reg ^ b0_reg) | 64'd1;
            OP_LSL:    simple_next = (am1 << sh) + 64'd1;
            OP_LSR:    simple_next = (am1 >> sh) | 64'd1;
            OP_ASR:    simple_next = 64'($signed(am1) >>> sh) | 64'd1;
            OP_ISINT:  simple_next = {62'd0, a0_reg[0], 1'b1};
            OP_NOT:    simple_next = 64'd4 - a0_reg;
            OP_EQ:     simple_next = tbool(a0_reg == b0_reg);
            OP_NEQ:    simple_next = tbool(a0_reg != b0_reg);
            OP_LT:     simple_next = tbool($signed(a0_reg) < $signed(b0_reg));
            OP_LE:     simple_next = tbool(!($signed(b0_reg) < $signed(a0_reg)));
            OP_GT:     simple_next = tbool($signed(b0_reg) < $signed(a0_reg));
            OP_GE:     simple_next = tbool(!($signed(a0_reg) < $signed(b0_reg)));
            OP_ULT:    simple_next = tbool(a0_reg < b0_reg);
            OP_UGE:    simple_next = tbool(a0_reg >= b0_reg);
            default:   simple_next = a0_reg;
        endcase
    end

    logic              v1_reg;
    logic [OP_W-1:0]   op1_reg;
    logic [WORD_W-1:0] simple1_reg, ll1_reg;
    logic [31:0]       lh1_reg, hl1_reg;
    logic [62:0]       n1_reg, d1_reg;
    logic              negq1_reg, negr1_reg, dz1_reg;
    logic [31:0]       lh_full, hl_full;

    // Only the low halves of the cross products reach the 64-bit result
    assign lh_full = ua[31:0] * ub[63:32];
    assign hl_full = ua[63:32] * ub[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg     <= op0_reg;
            simple1_reg <= simple_next;
            ll1_reg     <= ua[31:0] * ub[31:0];
            lh1_reg     <= lh_full;
            hl1_reg     <= hl_full;
            n1_reg      <= nabs[62:0];
            d1_reg      <= dabs[62:0];
            negq1_reg   <= ua[WORD_W-1] ^ ub[WORD_W-1];
            negr1_reg   <= ua[WORD_W-1];
            dz1_reg     <= (ub == 64'd0);
        end
    end

    // Divider stage array; index 0 is the product sum stage
    logic              dv_reg  [0:DIV_STEPS];
    logic [OP_W-1:0]   dop_reg [0:DIV_STEPS];
    logic [WORD_W-1:0] dres_reg[0:DIV_STEPS];
    logic [62:0]       rem_reg [0:DIV_STEPS];
    logic [62:0]       quo_reg [0:DIV_STEPS];
    logic [62:0]       dd_reg  [0:DIV_STEPS];
    logic              dnq_reg [0:DIV_STEPS];
    logic              dnr_reg [0:DIV_STEPS];
    logic              ddz_reg [0:DIV_STEPS];
    logic [63:0]       div_shift[1:DIV_STEPS];
    logic [64:0]       div_diff [1:DIV_STEPS];
    logic              div_ge   [1:DIV_STEPS];
    logic [WORD_W-1:0] mulsum;
    logic [31:0]       cross_sum;

    assign cross_sum = lh1_reg + hl1_reg;
    assign mulsum    = ll1_reg + {cross_sum, 32'd0};

    // Restoring division, one quotient bit per stage
    always_comb
    begin
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            div_shift[k] = {rem_reg[k-1], quo_reg[k-1][62]};
            div_diff[k]  = {1'b0, div_shift[k]} - {2'b00, dd_reg[k-1]};
            div_ge[k]    = !div_diff[k][64];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
                dv_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            dv_reg[0] <= v1_reg;
            for (int k = 1; k <= DIV_STEPS; k++)
                dv_reg[k] <= dv_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dop_reg[0]  <= op1_reg;
            dres_reg[0] <= (op1_reg == OP_MUL) ? {mulsum[62:0], 1'b1} : simple1_reg;
            rem_reg[0]  <= 63'd0;
            quo_reg[0]  <= n1_reg;
            dd_reg[0]   <= d1_reg;
            dnq_reg[0]  <= negq1_reg;
            dnr_reg[0]  <= negr1_reg;
            ddz_reg[0]  <= dz1_reg;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                dop_reg[k]  <= dop_reg[k-1];
                dres_reg[k] <= dres_reg[k-1];
                rem_reg[k]  <= div_ge[k] ? div_diff[k][62:0] : div_shift[k][62:0];
                quo_reg[k]  <= {quo_reg[k-1][61:0], div_ge[k]};
                dd_reg[k]   <= dd_reg[k-1];
                dnq_reg[k]  <= dnq_reg[k-1];
                dnr_reg[k]  <= dnr_reg[k-1];
                ddz_reg[k]  <= ddz_reg[k-1];
            end
        end
    end

    // Sign fix, tagging and output register
    logic              is_div, is_mod;
    logic [62:0]       mag_sel, signed_sel;
    logic              neg_sel;
    logic [WORD_W-1:0] result_next;
    logic              dz_next;

    assign is_div     = (dop_reg[DIV_STEPS] == OP_DIV);
    assign is_mod     = (dop_reg[DIV_STEPS] == OP_MOD);
    assign mag_sel    = is_div ? quo_reg[DIV_STEPS] : rem_reg[DIV_STEPS];
    assign neg_sel    = is_div ? dnq_reg[DIV_STEPS] : dnr_reg[DIV_STEPS];
    assign signed_sel = neg_sel ? (63'd0 - mag_sel) : mag_sel;

    always_comb
    begin
        dz_next     = 1'b0;
        result_next = dres_reg[DIV_STEPS];
        if (is_div || is_mod)
        begin
            if (ddz_reg[DIV_STEPS])
            begin
                result_next = 64'd1;
                dz_next     = 1'b1;
            end
            else
            begin
                result_next = {signed_sel, 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            out_valid <= dv_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_value   <= result_next;
            divide_by_zero <= dz_next;
        end
    end

    // Checks
    a_dz_gives_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> result_value == 64'd1)
        else $error("zero divisor result is not unit");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg[DIV_STEPS] && !ddz_reg[DIV_STEPS] && (is_div || is_mod)
        |-> rem_reg[DIV_STEPS] < dd_reg[DIV_STEPS])
        else $error("divider remainder not below divisor");

    a_dz_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg[0] && ddz_reg[0] |-> dd_reg[0] == 63'd0)
        else $error("zero divisor flag with nonzero divisor");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(dres_reg[DIV_STEPS]) && $stable(dv_reg[0]))
        else $error("pipeline moved while held");

endmodule
